// ===== rtl/cidf_pkg.sv =====
// Shared constants, register indexes, state and control types of the complex IIR filter.
`default_nettype none

package cidf_pkg;

    // Default build sizes
    localparam int MAX_ORDER_DEF    = 8;
    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int COEF_WIDTH_DEF   = 32;
    localparam int COEF_FRAC_DEF    = 20;

    // Fixed field widths of the interface
    localparam int ORDER_W    = 4;
    localparam int SCALE_W    = 32;
    localparam int CIDX_W     = 4;
    localparam int CFIELD_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int ACC_W      = 64;

    // Register reset values (scale is about 2^32 / 1071.238871)
    localparam logic [ORDER_W-1:0] ORDER_RST = 4'd1;
    localparam logic [SCALE_W-1:0] SCALE_RST = 32'd4009346;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORDER  = 2'd0,
        CFG_SCALE  = 2'd1,
        CFG_ENABLE = 2'd2
    } t_cfg_idx;

    // Item kinds carried in tuser
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_LOAD   = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PASS,
        ST_SCALE,
        ST_SHIFT,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND
    } t_state;

    // Per-lane control from the sequencer
    typedef struct packed {
        logic clear_hist;
        logic scale;
        logic shift_x;
        logic mac;
        logic sel_den;
        logic round;
    } t_lane_ctl;

endpackage

`default_nettype wire

// ===== rtl/cidf_lane.sv =====
// One filter lane: input scaling, history lines, shared multiply-accumulate and output rounding.
`default_nettype none

module cidf_lane #(
    parameter int MAX_ORDER    = cidf_pkg::MAX_ORDER_DEF,
    parameter int SAMPLE_WIDTH = cidf_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = cidf_pkg::COEF_WIDTH_DEF,
    parameter int COEF_FRAC    = cidf_pkg::COEF_FRAC_DEF,
    localparam int HI_W        = $clog2(MAX_ORDER + 1),
    localparam int YI_W        = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire cidf_pkg::t_lane_ctl               i_ctl,
    input  wire logic [cidf_pkg::SCALE_W-1:0]      i_scale,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    i_sample,
    input  wire logic signed [COEF_WIDTH-1:0]      i_coef,
    input  wire logic [HI_W-1:0]                   i_hidx,
    output logic signed [SAMPLE_WIDTH-1:0]         o_y
);
    import cidf_pkg::*;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int SPW  = SW + SCALE_W + 1;
    localparam int PW   = COEF_WIDTH + SW;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        $signed({{(ACC_W - SW + 1){1'b0}}, {(SW - 1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SAT_LO =
        $signed({{(ACC_W - SW + 1){1'b1}}, {(SW - 1){1'b0}}});
    localparam logic [ACC_W-1:0] RND_HALF = {{(ACC_W - COEF_FRAC){1'b0}}, 1'b1,
                                              {(COEF_FRAC - 1){1'b0}}};
    localparam logic [SPW-1:0]   SCL_HALF = {{(SPW - SCALE_W){1'b0}}, 1'b1,
                                              {(SCALE_W - 1){1'b0}}};

    logic signed [SW-1:0]     r_xh [0:MAX_ORDER];
    logic signed [SW-1:0]     r_yh [0:MAX_ORDER-1];
    logic signed [SPW-1:0]    r_sprod;
    logic signed [ACC_W-1:0]  r_prod;
    logic                     r_pv;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [SPW-1:0]    scl_mult;
    logic signed [SPW-1:0]    scl_rnd;
    logic signed [SW-1:0]     x_new;
    logic signed [SW-1:0]     hist_op;
    logic signed [PW-1:0]     mac_mult;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [ACC_W-1:0]  acc_q;

    // Input scaling, Q1.23 times unsigned Q0.32, rounded back to the sample grid
    assign scl_mult = SPW'(i_sample) * SPW'($signed({1'b0, i_scale}));
    assign scl_rnd  = r_sprod + $signed(SCL_HALF);
    assign x_new    = scl_rnd[SW+SCALE_W-1:SCALE_W];

    always_ff @(posedge i_clk) begin
        if (i_ctl.scale) begin
            r_sprod <= scl_mult;
        end
    end

    // Tap operand and product
    assign hist_op  = i_ctl.sel_den ? r_yh[i_hidx[YI_W-1:0]] : r_xh[i_hidx];
    assign mac_mult = PW'(i_coef) * PW'(hist_op);

    always_ff @(posedge i_clk) begin
        r_prod <= ACC_W'(mac_mult);
    end

    // Accumulator, wraps modulo 2^64
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_pv <= i_ctl.mac;
            if (i_ctl.shift_x) begin
                r_acc <= '0;
            end else if (r_pv) begin
                r_acc <= r_acc + r_prod;
            end
        end
    end

    // Round to the sample grid and saturate
    assign acc_rnd = r_acc + $signed(RND_HALF);
    assign acc_q   = acc_rnd >>> COEF_FRAC;

    always_comb begin
        if (acc_q > SAT_HI) begin
            o_y = SAT_HI[SW-1:0];
        end else if (acc_q < SAT_LO) begin
            o_y = SAT_LO[SW-1:0];
        end else begin
            o_y = acc_q[SW-1:0];
        end
    end

    // Input history, index 0 newest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear_hist) begin
            for (int i = 0; i <= MAX_ORDER; i++) begin
                r_xh[i] <= '0;
            end
        end else if (i_ctl.shift_x) begin
            r_xh[0] <= x_new;
            for (int i = 1; i <= MAX_ORDER; i++) begin
                r_xh[i] <= r_xh[i-1];
            end
        end
    end

    // Output history, index 0 is the last output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear_hist) begin
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_yh[i] <= '0;
            end
        end else if (i_ctl.round) begin
            r_yh[0] <= o_y;
            for (int i = 1; i < MAX_ORDER; i++) begin
                r_yh[i] <= r_yh[i-1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/complex_iir_direct_form_filter.sv =====
// Complex IIR filter: real and imaginary lanes share one tap sequencer and coefficient store.
// Flow: a filtered sample runs through the scale, shift, tap-walk, drain and round states (N = order in use);
//   a passed-through sample goes through the pass state; a coefficient load gives no word out.
// Throughput: no item is taken while a sample is in work, as each lane's single multiply-accumulate
//   walks the 2N+1 taps; the result register lets the next word in while one waits.
// Reset: synchronous, active low; clears control, restores register defaults and zeroes
//   coefficients and histories at once.
`default_nettype none

module complex_iir_direct_form_filter #(
    parameter int MAX_ORDER    = cidf_pkg::MAX_ORDER_DEF,
    parameter int SAMPLE_WIDTH = cidf_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = cidf_pkg::COEF_WIDTH_DEF,
    parameter int COEF_FRAC    = cidf_pkg::COEF_FRAC_DEF,
    localparam int IN_TDATA_W  = ((2 * SAMPLE_WIDTH + cidf_pkg::CIDX_W
                                   + 2 * cidf_pkg::CFIELD_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_wen,
    input  wire logic [cidf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [cidf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // sample_re, sample_im, coef_index, num_coef, den_coef, zero pad
    input  wire logic [IN_TDATA_W-1:0]               s_axis_tdata,
    input  wire logic                                s_axis_tuser,  // kind
    input  wire logic                                s_axis_tlast,  // end_of_block
    // output stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [OUT_TDATA_W-1:0]                   m_axis_tdata,  // out_re, out_im, zero pad
    output logic                                     m_axis_tlast   // out_end_of_block
);
    import cidf_pkg::*;

    localparam int SW      = SAMPLE_WIDTH;
    localparam int HI_W    = $clog2(MAX_ORDER + 1);
    localparam int YI_W    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int TAP_W   = $clog2(2 * MAX_ORDER + 1);
    localparam int LIDX_W  = (HI_W > CIDX_W) ? HI_W : CIDX_W;
    localparam int IM_LSB  = SW;
    localparam int IDX_LSB = 2 * SW;
    localparam int NUM_LSB = IDX_LSB + CIDX_W;
    localparam int DEN_LSB = NUM_LSB + CFIELD_W;

    // Configuration registers
    logic [ORDER_W-1:0]  r_order;
    logic [SCALE_W-1:0]  r_scale;
    logic                r_enable;

    // Coefficient store
    logic signed [COEF_WIDTH-1:0] r_num [0:MAX_ORDER];
    logic signed [COEF_WIDTH-1:0] r_den [0:MAX_ORDER-1];

    // Sequencer and captured item
    t_state              r_state, n_state;
    logic [TAP_W-1:0]    r_tap;
    logic signed [SW-1:0] r_re, r_im;
    logic                r_eob;

    // Result register
    logic                r_ovalid;
    logic signed [SW-1:0] r_out_re, r_out_im;
    logic                r_out_eob;

    logic                in_acc;
    logic                out_free;
    logic                load_out;
    t_lane_ctl           lane_ctl;
    logic [TAP_W-1:0]    n_eff;
    logic [TAP_W-1:0]    two_n;
    logic                sel_den;
    logic [TAP_W-1:0]    hidx_full;
    logic [TAP_W-1:0]    cidx_full;
    logic [HI_W-1:0]     hidx;
    logic [HI_W-1:0]     cidx;
    logic signed [COEF_WIDTH-1:0] coef;
    logic [LIDX_W-1:0]   ld_idx;
    logic [COEF_WIDTH-1:0] ld_num, ld_den;
    logic signed [SW-1:0] y_re, y_im;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order  <= ORDER_RST;
            r_scale  <= SCALE_RST;
            r_enable <= 1'b0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_ORDER:  r_order  <= i_cfg_data[ORDER_W-1:0];
                CFG_SCALE:  r_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    // Effective order: zero acts as one, clipped to the built maximum
    always_comb begin
        if (r_order == '0) begin
            n_eff = TAP_W'(1);
        end else if (int'(r_order) > MAX_ORDER) begin
            n_eff = TAP_W'(MAX_ORDER);
        end else begin
            n_eff = TAP_W'(r_order);
        end
    end
    assign two_n = n_eff << 1;

    // Coefficient loads
    assign ld_idx = LIDX_W'(s_axis_tdata[IDX_LSB +: CIDX_W]);
    assign ld_num = COEF_WIDTH'(s_axis_tdata[NUM_LSB +: CFIELD_W]);
    assign ld_den = COEF_WIDTH'(s_axis_tdata[DEN_LSB +: CFIELD_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= MAX_ORDER; i++) begin
                r_num[i] <= '0;
            end
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_den[i] <= '0;
            end
        end else if (in_acc && s_axis_tuser == KIND_LOAD) begin
            if (int'(ld_idx) <= MAX_ORDER) begin
                r_num[ld_idx[HI_W-1:0]] <= $signed(ld_num);
            end
            if (int'(ld_idx) < MAX_ORDER) begin
                r_den[ld_idx[YI_W-1:0]] <= $signed(ld_den);
            end
        end
    end

    // Capture the sample word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_re  <= $signed(s_axis_tdata[SW-1:0]);
            r_im  <= $signed(s_axis_tdata[IM_LSB +: SW]);
            r_eob <= s_axis_tlast;
        end
    end

    // Tap walk: numerator taps 0..N, then feedback taps
    assign sel_den   = r_tap > n_eff;
    assign hidx_full = sel_den ? (two_n - r_tap) : (n_eff - r_tap);
    assign cidx_full = sel_den ? (r_tap - n_eff - TAP_W'(1)) : r_tap;
    assign hidx      = hidx_full[HI_W-1:0];
    assign cidx      = cidx_full[HI_W-1:0];
    assign coef      = sel_den ? r_den[cidx[YI_W-1:0]] : r_num[cidx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else if (r_state == ST_SHIFT) begin
            r_tap <= '0;
        end else if (r_state == ST_MAC) begin
            r_tap <= r_tap + TAP_W'(1);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && s_axis_tuser == KIND_SAMPLE) begin
                    n_state = r_enable ? ST_SCALE : ST_PASS;
                end
            end
            ST_PASS:  if (out_free) n_state = ST_IDLE;
            ST_SCALE: n_state = ST_SHIFT;
            ST_SHIFT: n_state = ST_MAC;
            ST_MAC:   if (r_tap == two_n) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_ROUND;
            ST_ROUND: if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready       = 1'b0;
        load_out            = 1'b0;
        lane_ctl            = '0;
        lane_ctl.sel_den    = sel_den;
        lane_ctl.clear_hist = in_acc && s_axis_tuser == KIND_LOAD;
        case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_PASS:  load_out = out_free;
            ST_SCALE: lane_ctl.scale = 1'b1;
            ST_SHIFT: lane_ctl.shift_x = 1'b1;
            ST_MAC:   lane_ctl.mac = 1'b1;
            ST_DRAIN: ;
            ST_ROUND: begin
                load_out       = out_free;
                lane_ctl.round = out_free;
            end
            default:  ;
        endcase
    end

    // Lanes
    cidf_lane #(
        .MAX_ORDER    (MAX_ORDER),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .COEF_FRAC    (COEF_FRAC)
    ) u_lane_re (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_scale  (r_scale),
        .i_sample (r_re),
        .i_coef   (coef),
        .i_hidx   (hidx),
        .o_y      (y_re)
    );

    cidf_lane #(
        .MAX_ORDER    (MAX_ORDER),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COEF_WIDTH   (COEF_WIDTH),
        .COEF_FRAC    (COEF_FRAC)
    ) u_lane_im (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (lane_ctl),
        .i_scale  (r_scale),
        .i_sample (r_im),
        .i_coef   (coef),
        .i_hidx   (hidx),
        .o_y      (y_im)
    );

    // Merge lanes into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_re  <= (r_state == ST_ROUND) ? y_re : r_re;
            r_out_im  <= (r_state == ST_ROUND) ? y_im : r_im;
            r_out_eob <= r_eob;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out_im, r_out_re});
    assign m_axis_tlast  = r_out_eob;

endmodule

`default_nettype wire

// ===== rtl/cidf_checker.sv =====
// Port-level checks of the complex IIR filter, bound to the top level.
`default_nettype none

module cidf_checker #(
    parameter int OUT_TDATA_W = 48
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic                   s_axis_tuser,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   m_axis_tlast
);
    import cidf_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // Nothing is offered right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A sample word occupies the block: no new word next cycle
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_SAMPLE |=> !s_axis_tready)
        else $error("input taken while a sample is in work");

    // A new result only comes out of a sample in work
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without a sample in work");

endmodule

bind complex_iir_direct_form_filter cidf_checker #(
    .OUT_TDATA_W (OUT_TDATA_W)
) u_cidf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
